/* design/mrtu_pkg.sv */
// Shared types, constants and the CRC-16 helper of the Modbus RTU master link.
`timescale 1ns / 1ps
`default_nettype none
package mrtu_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam logic [8:0]  FRAME_BYTES_W = 9'(FRAME_BYTES);
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] TIMER_MAX = 16'hFFFF;
  localparam logic [7:0]  EXC_BIT = 8'h80;
  localparam logic [8:0]  EXC_LEN = 9'd5;
  localparam logic [8:0]  WRITE_LEN = 9'd8;
  localparam logic [8:0]  MIN_LEN = 9'd5;
  localparam logic [8:0]  READ_HDR = 9'd5;
  localparam logic [2:0]  TX_LAST = 3'd7;
  localparam logic [2:0]  TX_CRC_LO = 3'd6;
  localparam logic [2:0]  TX_DATA_END = 3'd5;

  localparam logic [7:0] FN_READ_COILS   = 8'd1;
  localparam logic [7:0] FN_READ_INPUTS  = 8'd4;
  localparam logic [7:0] FN_WRITE_COIL   = 8'd5;
  localparam logic [7:0] FN_WRITE_REG    = 8'd6;
  localparam logic [7:0] FN_WRITE_COILS  = 8'd15;
  localparam logic [7:0] FN_WRITE_REGS   = 8'd16;

  localparam logic REG_GAP_LIMIT = 1'b0;
  localparam logic REG_REQ_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RX   = 2'd1,
    ACT_TICK = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    K_TX_BYTE  = 3'd0,
    K_READ     = 3'd1,
    K_WRITE    = 3'd2,
    K_EXC      = 3'd3,
    K_PASS     = 3'd4,
    K_TIMEOUT  = 3'd5,
    K_REJECT   = 3'd6,
    K_BUF_DATA = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  server_address;
    logic [6:0]  resp_function;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [8:0]  frame_length;
    logic [7:0]  exception_code;
  } result_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/mrtu_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata0_o <= mem[raddr0_i];
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule
`default_nettype wire

/* design/modbus_rtu_master_link.sv */
// Top level of the Modbus RTU master link: request framing, response parsing, timers.
// Latency: every result appears in the cycle after its request is accepted; the eight
//   transmit bytes of a send request then follow one per cycle as the sink takes them.
// Throughput: one request per cycle while the output register drains; a send request
//   holds the input until its last byte is out; buffer reads use both frame RAM read ports.
// Reset: asynchronous, active low; clears the timers, the fill count, the running CRC
//   and the output register. The frame RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_master_link (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  dest_address_i,
  input  wire logic [7:0]  function_code_i,
  input  wire logic [15:0] start_field_i,
  input  wire logic [15:0] count_field_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [7:0]  buffer_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_o,
  output logic [7:0]       server_address_o,
  output logic [6:0]       resp_function_o,
  output logic [15:0]      first_value_o,
  output logic [15:0]      second_value_o,
  output logic [8:0]       frame_length_o,
  output logic [7:0]       exception_code_o,
  output logic [7:0]       data_byte_o,
  output logic [15:0]      data_word_o
);
  import mrtu_pkg::*;

  // Configuration registers.
  logic [15:0] gap_limit_q, req_limit_q;

  // Receive side state. The first six frame positions are mirrored in flops so
  // the frame decoder never waits for the RAM; the RAM serves buffer reads.
  logic [8:0]  fill_q, fill_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] gap_q, gap_d;
  logic [15:0] wait_q, wait_d;
  logic        busy_q, busy_d;
  logic [7:0]  req_addr_q, req_addr_d;
  logic [15:0] req_start_q, req_start_d;
  logic [15:0] req_count_q, req_count_d;
  logic [7:0]  sh_q [6];
  logic [7:0]  sh_b [6];

  // Transmit sequencer: a shift line of the six header bytes and a CRC folded
  // one byte per output cycle while the sink takes the bytes.
  logic        tx_active_q;
  logic [2:0]  tx_idx_q;
  logic [7:0]  txf_q [6];
  logic [15:0] txcrc_q;
  logic [15:0] txcrc_step;

  // Output register.
  logic        out_valid_q;
  result_t     out_q, res_d;
  logic        res_load;
  logic        rd_kind_q, rd_oor0_q, rd_oor1_q;

  logic        tx_pending, out_take, in_acc;
  action_e     act;

  assign act        = action_e'(action_i);
  assign tx_pending = tx_active_q && (tx_idx_q != TX_LAST);
  assign out_take   = out_valid_q && !out_stall_i;
  // The input waits only while the output register is occupied and cannot free up.
  assign in_stall_o = out_valid_q && (out_stall_i || tx_pending);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Frame RAM: written with each stored received byte, read for buffer requests.
  logic              ram_we;
  logic [7:0]        ram_q0, ram_q1;
  logic [8:0]        idx_next;
  logic              store_en;
  logic [8:0]        fill_a;

  assign idx_next = {1'b0, buffer_index_i} + 9'd1;
  assign ram_we   = in_acc && (act == ACT_RX) && store_en;

  mrtu_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (fill_a[FB_AW-1:0]),
    .wdata_i  (rx_byte_i),
    .re_i     (in_acc && (act == ACT_READ)),
    .raddr0_i (buffer_index_i[FB_AW-1:0]),
    .raddr1_i (idx_next[FB_AW-1:0]),
    .rdata0_o (ram_q0),
    .rdata1_o (ram_q1)
  );

  // Receive path working values.
  logic        gap_clear;
  logic [15:0] crc_a;
  logic [8:0]  fill_b;
  logic [15:0] crc_b;
  logic [15:0] wait_inc;
  logic [7:0]  fn_b;

  assign gap_clear = gap_q > gap_limit_q;
  assign fill_a    = gap_clear ? 9'd0 : fill_q;
  assign crc_a     = gap_clear ? CRC_INIT : crc_q;
  assign store_en  = fill_a < FRAME_BYTES_W;
  assign fill_b    = store_en ? fill_a + 9'd1 : fill_a;
  assign crc_b     = store_en ? crc_fold(crc_a, rx_byte_i) : crc_a;
  assign wait_inc  = (wait_q == TIMER_MAX) ? wait_q : wait_q + 16'd1;
  assign txcrc_step = crc_fold(txcrc_q, txf_q[0]);

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sh_b[k] = (store_en && (fill_a == 9'(k))) ? rx_byte_i : sh_q[k];
    end
  end
  assign fn_b = sh_b[1];

  always_comb begin
    logic done, frame_ok, is_exc, is_read, is_write;
    fill_d      = fill_q;
    crc_d       = crc_q;
    gap_d       = gap_q;
    wait_d      = wait_q;
    busy_d      = busy_q;
    req_addr_d  = req_addr_q;
    req_start_d = req_start_q;
    req_count_d = req_count_q;
    res_load    = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    done        = 1'b0;
    is_exc      = (fn_b & EXC_BIT) != 8'h00;
    is_read     = (fn_b >= FN_READ_COILS) && (fn_b <= FN_READ_INPUTS);
    is_write    = (fn_b == FN_WRITE_COIL) || (fn_b == FN_WRITE_REG) ||
                  (fn_b == FN_WRITE_COILS) || (fn_b == FN_WRITE_REGS);
    frame_ok    = (fill_b >= MIN_LEN) && (sh_b[0] == req_addr_q);
    if (in_acc) begin
      unique case (act)
        ACT_SEND: begin
          res_load = 1'b1;
          if (dest_address_i == 8'h00) begin
            res_d.kind = K_REJECT;
          end else begin
            res_d.kind    = K_TX_BYTE;
            res_d.tx_byte = dest_address_i;
            res_d.last    = 1'b0;
            req_addr_d    = dest_address_i;
            req_start_d   = start_field_i;
            req_count_d   = count_field_i;
            busy_d        = 1'b1;
            wait_d        = 16'd0;
          end
        end
        ACT_RX: begin
          gap_d  = 16'd0;
          fill_d = fill_b;
          crc_d  = crc_b;
          if (frame_ok) begin
            if (is_exc) begin
              done = fill_b == EXC_LEN;
            end else if (is_read) begin
              done = fill_b == ({1'b0, sh_b[2]} + READ_HDR);
            end else if (is_write) begin
              done = fill_b == WRITE_LEN;
            end else begin
              fill_d = 9'd0;
              crc_d  = CRC_INIT;
            end
          end
          if (done) begin
            fill_d               = 9'd0;
            crc_d                = CRC_INIT;
            res_d.server_address = sh_b[0];
            res_d.resp_function  = fn_b[6:0];
            res_d.frame_length   = fill_b;
            if (!busy_q) begin
              res_load   = 1'b1;
              res_d.kind = K_PASS;
            end else if (crc_b == 16'h0000) begin
              res_load = 1'b1;
              busy_d   = 1'b0;
              if (is_exc) begin
                res_d.kind           = K_EXC;
                res_d.exception_code = sh_b[2];
              end else if (is_read) begin
                res_d.kind         = K_READ;
                res_d.first_value  = req_start_q;
                res_d.second_value = req_count_q;
              end else begin
                res_d.kind         = K_WRITE;
                res_d.first_value  = {sh_b[2], sh_b[3]};
                res_d.second_value = {sh_b[4], sh_b[5]};
              end
            end
          end
        end
        ACT_TICK: begin
          gap_d = (gap_q == TIMER_MAX) ? gap_q : gap_q + 16'd1;
          if (busy_q) begin
            wait_d = wait_inc;
            if (wait_inc > req_limit_q) begin
              busy_d               = 1'b0;
              fill_d               = 9'd0;
              crc_d                = CRC_INIT;
              res_load             = 1'b1;
              res_d.kind           = K_TIMEOUT;
              res_d.server_address = req_addr_q;
            end
          end
        end
        ACT_READ: begin
          res_load   = 1'b1;
          res_d.kind = K_BUF_DATA;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= 16'd5;
      req_limit_q <= 16'd1000;
      fill_q      <= 9'd0;
      crc_q       <= CRC_INIT;
      gap_q       <= 16'd0;
      wait_q      <= 16'd0;
      busy_q      <= 1'b0;
      req_addr_q  <= 8'h00;
      req_start_q <= 16'd0;
      req_count_q <= 16'd0;
      tx_active_q <= 1'b0;
      tx_idx_q    <= 3'd0;
      txcrc_q     <= CRC_INIT;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      rd_kind_q   <= 1'b0;
      rd_oor0_q   <= 1'b0;
      rd_oor1_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_GAP_LIMIT: gap_limit_q <= cfg_wdata_i;
          REG_REQ_LIMIT: req_limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      fill_q      <= fill_d;
      crc_q       <= crc_d;
      gap_q       <= gap_d;
      wait_q      <= wait_d;
      busy_q      <= busy_d;
      req_addr_q  <= req_addr_d;
      req_start_q <= req_start_d;
      req_count_q <= req_count_d;

      if (res_load) begin
        out_valid_q <= 1'b1;
        out_q       <= res_d;
        rd_kind_q   <= res_d.kind == K_BUF_DATA;
        rd_oor0_q   <= {1'b0, buffer_index_i} >= FRAME_BYTES_W;
        rd_oor1_q   <= idx_next >= FRAME_BYTES_W;
        tx_active_q <= res_d.kind == K_TX_BYTE;
        tx_idx_q    <= 3'd0;
        txcrc_q     <= CRC_INIT;
      end else if (out_take && tx_pending) begin
        // Advance to the next frame byte; the header bytes feed the CRC as they go.
        tx_idx_q      <= tx_idx_q + 3'd1;
        out_q.last    <= (tx_idx_q + 3'd1) == TX_LAST;
        if (tx_idx_q <= TX_DATA_END) begin
          txcrc_q <= txcrc_step;
        end
        if (tx_idx_q < TX_DATA_END) begin
          out_q.tx_byte <= txf_q[1];
        end else if ((tx_idx_q + 3'd1) == TX_CRC_LO) begin
          out_q.tx_byte <= txcrc_step[7:0];
        end else begin
          out_q.tx_byte <= txcrc_q[15:8];
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
        tx_active_q <= 1'b0;
      end
    end
  end

  // Header shift line and receive mirrors carry payload only.
  always_ff @(posedge clk_i) begin
    if (in_acc && (act == ACT_SEND)) begin
      txf_q[0] <= dest_address_i;
      txf_q[1] <= function_code_i;
      txf_q[2] <= start_field_i[15:8];
      txf_q[3] <= start_field_i[7:0];
      txf_q[4] <= count_field_i[15:8];
      txf_q[5] <= count_field_i[7:0];
    end else if (out_take && tx_pending) begin
      for (int k = 0; k < 5; k++) begin
        txf_q[k] <= txf_q[k+1];
      end
    end
    if (ram_we) begin
      for (int k = 0; k < 6; k++) begin
        sh_q[k] <= sh_b[k];
      end
    end
  end

  logic [7:0] db0, db1;
  assign db0 = (rd_kind_q && !rd_oor0_q) ? ram_q0 : 8'h00;
  assign db1 = (rd_kind_q && !rd_oor1_q) ? ram_q1 : 8'h00;

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign tx_byte_o        = out_q.tx_byte;
  assign last_o           = out_q.last;
  assign server_address_o = out_q.server_address;
  assign resp_function_o  = out_q.resp_function;
  assign first_value_o    = out_q.first_value;
  assign second_value_o   = out_q.second_value;
  assign frame_length_o   = out_q.frame_length;
  assign exception_code_o = out_q.exception_code;
  assign data_byte_o      = db0;
  assign data_word_o      = {db0, db1};

endmodule
`default_nettype wire

/* design/mrtu_checker.sv */
// Port-level checker of the Modbus RTU master link, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mrtu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  action_i,
  input wire logic [7:0]  dest_address_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  kind_o,
  input wire logic        last_o,
  input wire logic [15:0] data_word_o
);
  import mrtu_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_tx_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (kind_o == K_TX_BYTE) && !last_o
    |=> out_valid_o && (kind_o == K_TX_BYTE))
    else $error("transmit frame interrupted");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != K_TX_BYTE) |-> last_o)
    else $error("event result without last");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_SEND) && (dest_address_i == 8'h00)
    |=> out_valid_o && (kind_o == K_REJECT))
    else $error("zero address request not rejected");

  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != K_BUF_DATA) |-> data_word_o == 16'h0000)
    else $error("data word set outside buffer read");

endmodule

bind modbus_rtu_master_link mrtu_checker u_mrtu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .action_i       (action_i),
  .dest_address_i (dest_address_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .last_o         (last_o),
  .data_word_o    (data_word_o)
);
`default_nettype wire

/* tb/tb_modbus_rtu_master_link.sv */
// Self-checking testbench of the Modbus RTU master link.
`timescale 1ns / 1ps
`default_nettype none
module tb_modbus_rtu_master_link;
  import mrtu_pkg::*;

  // One request on the input channel.
  typedef struct {
    action_e     act;
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [15:0] start;
    logic [15:0] count;
    logic [7:0]  rxb;
    logic [7:0]  idx;
  } link_req_t;

  // One result item, all eleven fields.
  typedef struct {
    kind_e       kind;
    logic [7:0]  tx;
    logic        last;
    logic [7:0]  srv;
    logic [6:0]  fn;
    logic [15:0] v1;
    logic [15:0] v2;
    logic [8:0]  len;
    logic [7:0]  exc;
    logic [7:0]  db;
    logic [15:0] dw;
  } link_res_t;

  // Directed row: the rx byte may be replaced by the CRC of the bytes received
  // since the last non-receive row (1 low byte, 2 high byte).
  typedef struct {
    link_req_t   rq;
    int          crc_sel;
    bit          typed;
    link_res_t   res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [7:0]  dest_address_i = '0;
  logic [7:0]  function_code_i = '0;
  logic [15:0] start_field_i = '0;
  logic [15:0] count_field_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  buffer_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [7:0]  server_address_o;
  logic [6:0]  resp_function_o;
  logic [15:0] first_value_o;
  logic [15:0] second_value_o;
  logic [8:0]  frame_length_o;
  logic [7:0]  exception_code_o;
  logic [7:0]  data_byte_o;
  logic [15:0] data_word_o;

  modbus_rtu_master_link DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow state of the link, kept in step with every accepted request.
  logic [7:0]  shadow_store [256];
  bit          store_written [256];
  int unsigned shadow_fill;
  logic [15:0] shadow_crc;
  logic [15:0] shadow_gap;
  bit          shadow_busy;
  logic [15:0] shadow_wait;
  logic [7:0]  shadow_addr;
  logic [15:0] shadow_start;
  logic [15:0] shadow_count;
  logic [15:0] gap_limit;
  logic [15:0] req_limit;

  link_res_t   expected_results [$];
  int          errors = 0;
  int          burst_left = 0;
  logic [15:0] stall_pattern = '0;
  int          stall_pos = 0;

  function automatic logic [15:0] modbus_crc(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) r = (r >> 1) ^ 16'hA001;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic link_res_t make_res(input kind_e k, input logic [7:0] tx, input logic lst,
      input logic [7:0] srv, input logic [7:0] fn, input logic [15:0] v1, input logic [15:0] v2,
      input logic [8:0] len, input logic [7:0] exc, input logic [7:0] db, input logic [15:0] dw);
    link_res_t r;
    r.kind = k; r.tx = tx; r.last = lst; r.srv = srv; r.fn = fn[6:0];
    r.v1 = v1; r.v2 = v2; r.len = len; r.exc = exc; r.db = db; r.dw = dw;
    return r;
  endfunction

  function automatic logic [7:0] store_byte(input int unsigned i);
    return (i > 255) ? 8'h00 : shadow_store[i];
  endfunction

  function automatic void clear_frame();
    shadow_fill = 0;
    shadow_crc = 16'hFFFF;
  endfunction

  // Receive path: store, fold into the CRC, then look for a complete frame.
  function automatic void predict_rx(input logic [7:0] b);
    logic [7:0] fn;
    bit done;
    logic [8:0] len;
    if (shadow_gap > gap_limit) clear_frame();
    shadow_gap = 0;
    if (shadow_fill < 256) begin
      shadow_store[shadow_fill] = b;
      store_written[shadow_fill] = 1'b1;
      shadow_fill++;
      shadow_crc = modbus_crc(shadow_crc, b);
    end
    if (shadow_fill < 5 || store_byte(0) != shadow_addr) return;
    fn = store_byte(1);
    if (fn[7]) done = (shadow_fill == 5);
    else if (fn >= 1 && fn <= 4) done = (shadow_fill == store_byte(2) + 5);
    else if (fn == 5 || fn == 6 || fn == 15 || fn == 16) done = (shadow_fill == 8);
    else begin
      clear_frame();
      return;
    end
    if (!done) return;
    len = 9'(shadow_fill);
    if (!shadow_busy) begin
      // Nothing outstanding: the frame passes through without a CRC check.
      expected_results.push_back(make_res(K_PASS, 0, 1, store_byte(0), fn, 0, 0, len, 0, 0, 0));
      clear_frame();
      return;
    end
    if (shadow_crc != 0) begin
      // A corrupted answer is dropped silently and the request stays open.
      clear_frame();
      return;
    end
    if (fn[7])
      expected_results.push_back(make_res(K_EXC, 0, 1, store_byte(0), fn, 0, 0, len,
                                          store_byte(2), 0, 0));
    else if (fn <= 4)
      expected_results.push_back(make_res(K_READ, 0, 1, store_byte(0), fn, shadow_start,
                                          shadow_count, len, 0, 0, 0));
    else
      expected_results.push_back(make_res(K_WRITE, 0, 1, store_byte(0), fn,
                                          {store_byte(2), store_byte(3)},
                                          {store_byte(4), store_byte(5)}, len, 0, 0, 0));
    shadow_busy = 0;
    clear_frame();
  endfunction

  // Works out every result one accepted request causes.
  function automatic void predict_link(input link_req_t q);
    logic [7:0] frame [8];
    logic [15:0] c;
    case (q.act)
      ACT_SEND: begin
        if (q.addr == 0) begin
          expected_results.push_back(make_res(K_REJECT, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        end else begin
          frame[0] = q.addr; frame[1] = q.fn;
          frame[2] = q.start[15:8]; frame[3] = q.start[7:0];
          frame[4] = q.count[15:8]; frame[5] = q.count[7:0];
          c = 16'hFFFF;
          for (int i = 0; i < 6; i++) c = modbus_crc(c, frame[i]);
          frame[6] = c[7:0]; frame[7] = c[15:8];
          for (int i = 0; i < 8; i++)
            expected_results.push_back(make_res(K_TX_BYTE, frame[i], i == 7, 0, 0, 0, 0, 0,
                                                0, 0, 0));
          shadow_addr = q.addr; shadow_start = q.start; shadow_count = q.count;
          shadow_busy = 1; shadow_wait = 0;
        end
      end
      ACT_RX: predict_rx(q.rxb);
      ACT_TICK: begin
        if (shadow_gap != 16'hFFFF) shadow_gap++;
        if (shadow_busy) begin
          if (shadow_wait != 16'hFFFF) shadow_wait++;
          if (shadow_wait > req_limit) begin
            shadow_busy = 0;
            clear_frame();
            expected_results.push_back(make_res(K_TIMEOUT, 0, 1, shadow_addr, 0, 0, 0, 0, 0,
                                                0, 0));
          end
        end
      end
      default: begin
        expected_results.push_back(make_res(K_BUF_DATA, 0, 1, 0, 0, 0, 0, 0, 0,
            store_byte(q.idx), {store_byte(q.idx), store_byte(q.idx + 1)}));
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Sends one request, in bursts with random gaps, and predicts on acceptance.
  task automatic send_request(input link_req_t q, input bit typed, input link_res_t res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= q.act;
    dest_address_i <= q.addr;
    function_code_i <= q.fn;
    start_field_i <= q.start;
    count_field_i <= q.count;
    rx_byte_i <= q.rxb;
    buffer_index_i <= q.idx;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (typed) begin
      // The shadow state still advances; the typed answer replaces the prediction.
      predict_link(q);
      expected_results.pop_back();
      expected_results.push_back(res);
    end else begin
      predict_link(q);
    end
  endtask

  task automatic issue(input link_req_t q);
    link_res_t none;
    send_request(q, 1'b0, none);
  endtask

  function automatic link_req_t rand_req(input action_e a);
    link_req_t q;
    q.act = a;
    q.addr = $urandom; q.fn = $urandom; q.start = $urandom; q.count = $urandom;
    q.rxb = $urandom; q.idx = $urandom;
    return q;
  endfunction

  task automatic rx_byte(input logic [7:0] b);
    link_req_t q;
    q = rand_req(ACT_RX);
    q.rxb = b;
    issue(q);
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_GAP_LIMIT) gap_limit = val;
    else req_limit = val;
  endtask

  // A server answer to the open request, now and then with a broken byte.
  task automatic answer();
    logic [7:0] bytes [$];
    logic [15:0] c;
    int sel;
    int n;
    bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : shadow_addr);
    sel = $urandom_range(0, 3);
    case (sel)
      0: begin
        n = $urandom_range(0, 6);
        bytes.push_back(8'($urandom_range(1, 4)));
        bytes.push_back(8'(n));
        repeat (n) bytes.push_back(8'($urandom));
      end
      1: begin
        case ($urandom_range(0, 3))
          0: bytes.push_back(FN_WRITE_COIL);
          1: bytes.push_back(FN_WRITE_REG);
          2: bytes.push_back(FN_WRITE_COILS);
          default: bytes.push_back(FN_WRITE_REGS);
        endcase
        repeat (4) bytes.push_back(8'($urandom));
      end
      2: begin
        bytes.push_back(EXC_BIT | 8'($urandom_range(0, 127)));
        bytes.push_back(8'($urandom));
      end
      default: begin
        // Unknown function code: the frame is thrown away.
        bytes.push_back(8'($urandom_range(17, 127)));
        repeat (4) bytes.push_back(8'($urandom));
      end
    endcase
    c = 16'hFFFF;
    foreach (bytes[i]) c = modbus_crc(c, bytes[i]);
    bytes.push_back(c[7:0]);
    bytes.push_back(c[15:8]);
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(0, bytes.size() - 1);
      bytes[n] = bytes[n] ^ 8'($urandom_range(1, 255));
    end
    foreach (bytes[i]) begin
      if ($urandom_range(0, 19) == 0) issue(rand_req(ACT_TICK));
      rx_byte(bytes[i]);
    end
  endtask

  function automatic logic [7:0] readable_index();
    logic [7:0] i;
    do i = $urandom; while (!(store_written[i] && (i == 255 || store_written[i + 1])));
    return i;
  endfunction

  // Receiver stall pattern, changed by phase; an all-zero pattern never stalls.
  always @(negedge clk_i) begin
    out_stall_i <= stall_pattern[stall_pos];
    stall_pos <= (stall_pos + 1) % 16;
  end

  always @(posedge clk_i) begin
    link_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report("result with nothing expected, kind", kind_o, 0);
      end else begin
        e = expected_results.pop_front();
        if (kind_o != e.kind) report("kind", kind_o, e.kind);
        if (tx_byte_o != e.tx) report("tx_byte", tx_byte_o, e.tx);
        if (last_o != e.last) report("last", last_o, e.last);
        if (server_address_o != e.srv) report("server_address", server_address_o, e.srv);
        if (resp_function_o != e.fn) report("resp_function", resp_function_o, e.fn);
        if (first_value_o != e.v1) report("first_value", first_value_o, e.v1);
        if (second_value_o != e.v2) report("second_value", second_value_o, e.v2);
        if (frame_length_o != e.len) report("frame_length", frame_length_o, e.len);
        if (exception_code_o != e.exc) report("exception_code", exception_code_o, e.exc);
        if (data_byte_o != e.db) report("data_byte", data_byte_o, e.db);
        if (data_word_o != e.dw) report("data_word", data_word_o, e.dw);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t r;
    link_res_t none;
    logic [15:0] run_crc;
    link_req_t q;
    int flood_at;
    logic [15:0] gap_set [6];
    logic [15:0] req_set [6];
    int phase_items;

    foreach (shadow_store[i]) begin
      shadow_store[i] = 8'h00;
      store_written[i] = 1'b0;
    end
    clear_frame();
    shadow_gap = 0; shadow_busy = 0; shadow_wait = 0;
    shadow_addr = 0; shadow_start = 0; shadow_count = 0;
    gap_limit = 16'd5; req_limit = 16'd1000;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table. A zero address is refused with a fixed answer.
    r.crc_sel = 0; r.typed = 0; r.res = none;
    r.rq = rand_req(ACT_SEND); r.rq.addr = 0; r.typed = 1;
    r.res = make_res(K_REJECT, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    rows.push_back(r);
    r.typed = 0;
    // All-ones request, then a second one that replaces it while busy.
    r.rq = rand_req(ACT_SEND); r.rq.addr = 8'hFF; r.rq.fn = 8'hFF;
    r.rq.start = 16'hFFFF; r.rq.count = 16'hFFFF; rows.push_back(r);
    r.rq = rand_req(ACT_SEND); r.rq.addr = 8'h11; r.rq.fn = 8'h03;
    r.rq.start = 16'h0000; r.rq.count = 16'h0001; rows.push_back(r);
    // Read answer with two data bytes and a good CRC.
    r.rq = rand_req(ACT_RX); r.rq.rxb = 8'h11; rows.push_back(r);
    r.rq.rxb = 8'h03; rows.push_back(r);
    r.rq.rxb = 8'h02; rows.push_back(r);
    r.rq.rxb = 8'hAB; rows.push_back(r);
    r.rq.rxb = 8'hCD; rows.push_back(r);
    r.crc_sel = 1; rows.push_back(r);
    r.crc_sel = 2; rows.push_back(r);
    r.crc_sel = 0;
    r.rq = rand_req(ACT_READ); r.rq.idx = 8'd0; rows.push_back(r);
    r.rq.idx = 8'd3; rows.push_back(r);
    // Exception answer to a fresh request.
    r.rq = rand_req(ACT_SEND); r.rq.addr = 8'h11; r.rq.fn = 8'h01; rows.push_back(r);
    r.rq = rand_req(ACT_RX); r.rq.rxb = 8'h11; rows.push_back(r);
    r.rq.rxb = 8'h81; rows.push_back(r);
    r.rq.rxb = 8'h02; rows.push_back(r);
    r.crc_sel = 1; rows.push_back(r);
    r.crc_sel = 2; rows.push_back(r);
    r.crc_sel = 0;
    // Nothing open now: an answer passes through, CRC unchecked.
    r.rq.rxb = 8'h11; rows.push_back(r);
    r.rq.rxb = 8'h81; rows.push_back(r);
    r.rq.rxb = 8'h05; rows.push_back(r);
    r.rq.rxb = 8'h00; rows.push_back(r);
    rows.push_back(r);
    // A tick with nothing open gives no result.
    r.rq = rand_req(ACT_TICK); rows.push_back(r);

    run_crc = 16'hFFFF;
    foreach (rows[i]) begin
      q = rows[i].rq;
      if (q.act != ACT_RX) run_crc = 16'hFFFF;
      else begin
        if (rows[i].crc_sel == 1) q.rxb = run_crc[7:0];
        else if (rows[i].crc_sel == 2) q.rxb = run_crc[15:8];
        run_crc = modbus_crc(run_crc, q.rxb);
      end
      send_request(q, rows[i].typed, rows[i].res);
    end
    drain();

    // Random phases, each with its own register settings and stall pattern.
    gap_set = '{16'd0, 16'd5, 16'd65535, 16'd2, 16'd0, 16'd65535};
    req_set = '{16'd0, 16'd1000, 16'd65535, 16'd3, 16'd65535, 16'd6};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GAP_LIMIT, gap_set[ph]);
      write_reg(REG_REQ_LIMIT, req_set[ph]);
      // One slot of every pattern stays open so the receiver never stalls for good.
      case (ph % 3)
        0: stall_pattern = 16'h0000;
        1: stall_pattern = 16'($urandom) & 16'hFFFE;
        default: stall_pattern = (16'hF0F0 | 16'($urandom)) & 16'h7FFF;
      endcase
      if (ph == 0) begin
        // Fill the whole store with a frame whose address never matches,
        // pushing two bytes past the end of the buffer.
        issue(rand_req(ACT_TICK));
        rx_byte(shadow_addr ^ 8'h01);
        for (flood_at = 1; flood_at < 258; flood_at++) rx_byte(8'($urandom));
        q = rand_req(ACT_READ); q.idx = 8'd255; issue(q);
        issue(rand_req(ACT_TICK));
      end
      phase_items = 0;
      while (phase_items < 12) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
            q = rand_req(ACT_SEND);
            if ($urandom_range(0, 9) == 0) q.addr = 0;
            issue(q);
            if (q.addr != 0) begin
              repeat ($urandom_range(0, 2)) issue(rand_req(ACT_TICK));
              answer();
            end
            phase_items += 8;
          end
          10, 11, 12: begin
            repeat ($urandom_range(1, 5)) issue(rand_req(ACT_TICK));
            phase_items += 3;
          end
          13, 14, 15: begin
            q = rand_req(ACT_READ);
            q.idx = readable_index();
            issue(q);
            phase_items++;
          end
          16, 17: begin
            issue(rand_req(ACT_RX));
            phase_items++;
          end
          default: begin
            issue(rand_req(ACT_SEND));
            phase_items++;
          end
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
